/* hw/rtl/u16u8_pkg.sv */
package u16u8_pkg;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Code point limits and the replacement character.
    localparam logic [20:0] CP_MAX_1B  = 21'h00007F;
    localparam logic [20:0] CP_MAX_2B  = 21'h0007FF;
    localparam logic [20:0] CP_MAX_3B  = 21'h00FFFF;
    localparam logic [20:0] CP_SUPP    = 21'h010000;
    localparam logic [20:0] CP_REPL    = 21'h00FFFD;

    // Number of bytes in front of the main code point when a replacement leads.
    localparam logic [2:0] REPL_LEN = 3'd3;

    // One decoded request: an optional leading U+FFFD and an optional code point.
    typedef struct packed {
        logic        pre_rep;
        logic        has_main;
        logic        main_rep;
        logic [20:0] cp;
    } job_t;

    // Length of the UTF-8 form of a code point.
    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp <= CP_MAX_1B) begin
            n = 3'd1;
        end else if (cp <= CP_MAX_2B) begin
            n = 3'd2;
        end else if (cp <= CP_MAX_3B) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    // Byte k of the UTF-8 form of a code point.
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] k);
        logic [7:0] b;
        b = 8'h00;
        case (utf8_len(cp))
            3'd1: b = {1'b0, cp[6:0]};
            3'd2: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3:
            begin
                case (k)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                case (k)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/u16u8_if.sv */
// Input channel: one UTF-16 code unit per request.
interface u16u8_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        final_unit;

    modport source (output valid, output code_unit, output final_unit, input ready);
    modport sink   (input valid, input code_unit, input final_unit, output ready);
endinterface

// Output channel: one UTF-8 byte per request.
interface u16u8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;
    logic       replaced;

    modport source (output valid, output out_byte, output last_byte, output replaced,
                    input ready);
    modport sink   (input valid, input out_byte, input last_byte, input replaced,
                    output ready);
endinterface

/* hw/rtl/utf16_to_utf8_transcoder.sv */
// The front writes each unit's job into the queue, and the back loads its bytes
// into the single output byte register. Throughput: one output byte per cycle
// while the receiver is ready and a job is queued. A unit gives 1 to 3 bytes for a
// BMP unit, 4 for a pair and up to 6 with a replacement; the queue takes new units
// while the back is still emitting. Units that give no bytes push nothing.
// Reset: rst_n clears the pending surrogate, empties the queue and drops the
// output register at once; no clearing pass is needed.
module utf16_to_utf8_transcoder (
    input  logic           clk,
    input  logic           rst_n,
    u16u8_unit_if.sink     unit_ch,
    u16u8_byte_if.source   byte_ch
);

    u16u8_pkg::job_t push_job;
    u16u8_pkg::job_t head;
    logic            push;
    logic            pop;
    logic            empty;
    logic            full;

    // Classify units and track surrogates.
    u16u8_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .unit_ch (unit_ch),
        .q_full  (full),
        .push    (push),
        .job     (push_job)
    );

    // Decouple the front from the byte sequencer.
    u16u8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    // Emit UTF-8 bytes.
    u16u8_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .empty   (empty),
        .pop     (pop),
        .byte_ch (byte_ch)
    );

endmodule

/* hw/rtl/u16u8_front.sv */
module u16u8_front (
    input  logic               clk,
    input  logic               rst_n,
    u16u8_unit_if.sink         unit_ch,
    input  logic               q_full,
    output logic               push,
    output u16u8_pkg::job_t    job
);

    logic       pend_reg;
    logic       pend_next;
    logic [9:0] hb_reg;
    logic [9:0] hb_next;
    logic       accept;
    logic       is_high;
    logic       is_low;
    logic       is_zero;

    assign unit_ch.ready = !q_full;
    assign accept        = unit_ch.valid && unit_ch.ready;

    assign is_high = (unit_ch.code_unit[15:10] == 6'b110110);
    assign is_low  = (unit_ch.code_unit[15:10] == 6'b110111);
    assign is_zero = (unit_ch.code_unit == 16'h0000);

    // Classify the unit against the pending high surrogate.
    always_comb
    begin
        job       = '0;
        pend_next = pend_reg;
        hb_next   = hb_reg;
        if (pend_reg && is_low) begin
            job.has_main = 1'b1;
            job.cp       = u16u8_pkg::CP_SUPP + {1'b0, hb_reg, unit_ch.code_unit[9:0]};
            pend_next    = 1'b0;
            hb_next      = '0;
        end else begin
            job.pre_rep = pend_reg;
            pend_next   = 1'b0;
            hb_next     = '0;
            if (is_zero) begin
                job.has_main = 1'b0;
            end else if (is_high) begin
                if (unit_ch.final_unit) begin
                    job.has_main = 1'b1;
                    job.main_rep = 1'b1;
                    job.cp       = u16u8_pkg::CP_REPL;
                end else begin
                    pend_next = 1'b1;
                    hb_next   = unit_ch.code_unit[9:0];
                end
            end else if (is_low) begin
                job.has_main = 1'b1;
                job.main_rep = 1'b1;
                job.cp       = u16u8_pkg::CP_REPL;
            end else begin
                job.has_main = 1'b1;
                job.cp       = {5'd0, unit_ch.code_unit};
            end
            if (unit_ch.final_unit) begin
                pend_next = 1'b0;
                hb_next   = '0;
            end
        end
    end

    // Units that give no bytes leave nothing in the queue.
    assign push = accept && (job.pre_rep || job.has_main);

    // Surrogate state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg <= 1'b0;
            hb_reg   <= '0;
        end else if (accept) begin
            pend_reg <= pend_next;
            hb_reg   <= hb_next;
        end
    end

    // A final unit never leaves a surrogate pending.
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && unit_ch.final_unit |=> !pend_reg)
        else $error("surrogate still pending after a final unit");

endmodule

/* hw/rtl/u16u8_queue.sv */
module u16u8_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  u16u8_pkg::job_t    push_job,
    input  logic               pop,
    output u16u8_pkg::job_t    head,
    output logic               empty,
    output logic               full
);

    u16u8_pkg::job_t                   mem [u16u8_pkg::QDEPTH];
    logic [u16u8_pkg::QPTR_W-1:0]      wr_reg;
    logic [u16u8_pkg::QPTR_W-1:0]      rd_reg;
    logic [u16u8_pkg::QCNT_W-1:0]      cnt_reg;
    logic                              do_push;
    logic                              do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == u16u8_pkg::QCNT_W'(u16u8_pkg::QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == u16u8_pkg::QPTR_W'(u16u8_pkg::QDEPTH - 1)) ?
                          '0 : wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == u16u8_pkg::QPTR_W'(u16u8_pkg::QDEPTH - 1)) ?
                          '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // The front only writes when there is room.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= u16u8_pkg::QCNT_W'(u16u8_pkg::QDEPTH))
        else $error("queue fill count out of range");

endmodule

/* hw/rtl/u16u8_back.sv */
module u16u8_back (
    input  logic               clk,
    input  logic               rst_n,
    input  u16u8_pkg::job_t    head,
    input  logic               empty,
    output logic               pop,
    u16u8_byte_if.source       byte_ch
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       rep_reg;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic [2:0] pre_len;
    logic [2:0] total;
    logic [2:0] main_idx;
    logic       load;
    logic       in_pre;
    logic       is_last;
    logic [7:0] cur_byte;
    logic       cur_rep;

    assign byte_ch.valid     = valid_reg;
    assign byte_ch.out_byte  = byte_reg;
    assign byte_ch.last_byte = last_reg;
    assign byte_ch.replaced  = rep_reg;

    // Walk the bytes of the head request, one per cycle while the output can take a byte.
    always_comb
    begin
        pre_len  = head.pre_rep ? u16u8_pkg::REPL_LEN : 3'd0;
        total    = pre_len + (head.has_main ? u16u8_pkg::utf8_len(head.cp) : 3'd0);
        in_pre   = head.pre_rep && (idx_reg < u16u8_pkg::REPL_LEN);
        main_idx = idx_reg - pre_len;
        if (in_pre) begin
            cur_byte = u16u8_pkg::utf8_byte(u16u8_pkg::CP_REPL, idx_reg[1:0]);
            cur_rep  = 1'b1;
        end else begin
            cur_byte = u16u8_pkg::utf8_byte(head.cp, main_idx[1:0]);
            cur_rep  = head.main_rep;
        end
        is_last  = (idx_reg == total - 3'd1);
        load     = !empty && (!valid_reg || byte_ch.ready);
        pop      = load && is_last;
        idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
    end

    // Output register and byte counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            byte_reg  <= '0;
            last_reg  <= 1'b0;
            rep_reg   <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                byte_reg  <= cur_byte;
                last_reg  <= is_last;
                rep_reg   <= cur_rep;
                idx_reg   <= idx_next;
            end else if (byte_ch.ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // One unit gives at most six bytes.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 3'd5)
        else $error("byte index out of range");

    // Replacement bytes are always part of EF BF BD.
    a_repl_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && rep_reg |->
        (byte_reg == 8'hEF) || (byte_reg == 8'hBF) || (byte_reg == 8'hBD))
        else $error("replacement byte is not part of U+FFFD");

    // The counter starts over after the last byte of a unit.
    a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 3'd0))
        else $error("byte index did not restart after a unit");

endmodule

/* bench/transcode_check.sv */
`timescale 1ns / 1ps

// Watches both channels of the transcoder, predicts the UTF-8 bytes of every
// accepted code unit request and compares each accepted byte request in order.
module transcode_check (
    input  logic    clk,
    input  logic    rst_n,
    u16u8_unit_if   unit_ch,
    u16u8_byte_if   byte_ch,
    output int      fail_count,
    output int      expected_left
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       rep;
    } utf8_byte_t;

    // Bytes still owed by the block, oldest first.
    utf8_byte_t utf8_due[$];

    // Our own copy of the pending high surrogate.
    logic       surr_held;
    logic [9:0] surr_bits;

    function automatic void queue_byte(input logic [7:0] data, input logic rep);
        utf8_byte_t b;
        b.data = data;
        b.last = 1'b0;
        b.rep  = rep;
        utf8_due.push_back(b);
    endfunction

    // Append the UTF-8 encoding of one code point.
    function automatic void queue_code_point(input logic [20:0] cp, input logic rep);
        if (cp <= u16u8_pkg::CP_MAX_1B)
        begin
            queue_byte(cp[7:0], rep);
        end
        else if (cp <= u16u8_pkg::CP_MAX_2B)
        begin
            queue_byte(8'hC0 | 8'(cp[10:6]), rep);
            queue_byte(8'h80 | 8'(cp[5:0]), rep);
        end
        else if (cp <= u16u8_pkg::CP_MAX_3B)
        begin
            queue_byte(8'hE0 | 8'(cp[15:12]), rep);
            queue_byte(8'h80 | 8'(cp[11:6]), rep);
            queue_byte(8'h80 | 8'(cp[5:0]), rep);
        end
        else
        begin
            queue_byte(8'hF0 | 8'(cp[20:18]), rep);
            queue_byte(8'h80 | 8'(cp[17:12]), rep);
            queue_byte(8'h80 | 8'(cp[11:6]), rep);
            queue_byte(8'h80 | 8'(cp[5:0]), rep);
        end
    endfunction

    // Work out the bytes that one code unit releases and update the surrogate state.
    function automatic void transcode_unit(input logic [15:0] code, input logic fin);
        int         first;
        logic       is_high;
        logic       is_low;
        logic       paired;
        utf8_byte_t tail;
        first   = utf8_due.size();
        is_high = (code[15:10] == 6'b110110);
        is_low  = (code[15:10] == 6'b110111);
        paired  = 1'b0;

        // A pending high surrogate is either completed or replaced.
        if (surr_held)
        begin
            surr_held = 1'b0;
            if (is_low)
            begin
                queue_code_point(u16u8_pkg::CP_SUPP + 21'({surr_bits, code[9:0]}), 1'b0);
                paired = 1'b1;
            end
            else
            begin
                queue_code_point(u16u8_pkg::CP_REPL, 1'b1);
            end
            surr_bits = '0;
        end

        // Otherwise the unit stands on its own.
        if (!paired)
        begin
            if (code == 16'h0000)
            begin
                surr_held = 1'b0;
                surr_bits = '0;
            end
            else if (is_high)
            begin
                if (fin)
                begin
                    queue_code_point(u16u8_pkg::CP_REPL, 1'b1);
                end
                else
                begin
                    surr_held = 1'b1;
                    surr_bits = code[9:0];
                end
            end
            else if (is_low)
            begin
                queue_code_point(u16u8_pkg::CP_REPL, 1'b1);
            end
            else
            begin
                queue_code_point({5'd0, code}, 1'b0);
            end
            if (fin)
            begin
                surr_held = 1'b0;
                surr_bits = '0;
            end
        end

        // Mark the last byte that this unit releases.
        if (utf8_due.size() > first)
        begin
            tail = utf8_due.pop_back();
            tail.last = 1'b1;
            utf8_due.push_back(tail);
        end
    endfunction

    // Predict on every accepted unit, compare on every accepted byte.
    always @(posedge clk or negedge rst_n)
    begin : watch
        utf8_byte_t want;
        if (!rst_n)
        begin
            utf8_due.delete();
            surr_held = 1'b0;
            surr_bits = '0;
            fail_count = 0;
            expected_left <= 0;
        end
        else
        begin
            if (unit_ch.valid && unit_ch.ready)
            begin
                transcode_unit(unit_ch.code_unit, unit_ch.final_unit);
            end
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (utf8_due.size() == 0)
                begin
                    $display("%0t: expected no byte, got %02h last %0b replaced %0b", $time,
                             byte_ch.out_byte, byte_ch.last_byte, byte_ch.replaced);
                    fail_count++;
                end
                else
                begin
                    want = utf8_due.pop_front();
                    if (byte_ch.out_byte !== want.data || byte_ch.last_byte !== want.last ||
                        byte_ch.replaced !== want.rep)
                    begin
                        $display("%0t: expected byte %02h last %0b replaced %0b, got %02h %0b %0b",
                                 $time, want.data, want.last, want.rep,
                                 byte_ch.out_byte, byte_ch.last_byte, byte_ch.replaced);
                        fail_count++;
                    end
                end
            end
            expected_left <= utf8_due.size();
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_UNITS = 80;
    localparam int DRAIN_TAIL   = 8;

    logic clk;
    logic rst_n;
    logic hold_off_go;
    int   fail_count;
    int   expected_left;
    int   tx_burst;
    int   tx_calm;
    int   rx_calm;
    int   stall_cycles;

    u16u8_unit_if unit_if ();
    u16u8_byte_if byte_if ();

    utf16_to_utf8_transcoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .unit_ch (unit_if),
        .byte_ch (byte_if)
    );

    transcode_check check_u (
        .clk           (clk),
        .rst_n         (rst_n),
        .unit_ch       (unit_if),
        .byte_ch       (byte_if),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, and now and then a calm stretch.
    function automatic int next_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (r < 5)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // A random non-surrogate unit from the 1-, 2- or 3-byte ranges.
    function automatic logic [15:0] random_bmp();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(16'h0001, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function automatic logic random_final();
        return ($urandom_range(0, 9) == 0);
    endfunction

    // Offer one unit request after an optional gap and wait until it is taken.
    task automatic send_unit(input logic [15:0] code, input logic fin);
        int gap;
        gap = (tx_burst > 0) ? 0 : next_gap(tx_calm);
        if (tx_burst > 0)
            tx_burst--;
        if (gap > 0)
        begin
            if (unit_if.valid)
                unit_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        unit_if.valid      <= 1'b1;
        unit_if.code_unit  <= code;
        unit_if.final_unit <= fin;
        do @(posedge clk); while (!unit_if.ready);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (expected_left != 0);
    endtask

    // Byte receiver: random stalls, plus one long hold-off that fills the block.
    initial
    begin : sink_drive
        int gap;
        bit held_done;
        gap = 0;
        held_done = 1'b0;
        rx_calm = 0;
        byte_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_go && !held_done)
            begin
                held_done = 1'b1;
                byte_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                gap = 0;
            end
            else if (gap > 0)
            begin
                byte_if.ready <= 1'b0;
                gap--;
            end
            else
            begin
                byte_if.ready <= 1'b1;
                gap = next_gap(rx_calm);
            end
        end
    end

    // Watchdog on cycles without any accepted request.
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles = 0;
        else if ((unit_if.valid && unit_if.ready) || (byte_if.valid && byte_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus: reset, directed units, then random units, then the verdict.
    initial
    begin : stimulus
        int  sent;
        int  pick;
        bit  hold_started;
        bit  paused;
        sent = 0;
        hold_started = 1'b0;
        paused = 1'b0;
        tx_burst = 0;
        tx_calm = 0;
        rst_n              <= 1'b0;
        hold_off_go        <= 1'b0;
        unit_if.valid      <= 1'b0;
        unit_if.code_unit  <= 16'h0000;
        unit_if.final_unit <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Range edges of the 1-, 2- and 3-byte forms.
        send_unit(16'h0041, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        // Lowest and highest surrogate pairs.
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        // Lone low surrogates.
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        // High surrogate broken by a plain unit, then by another high one.
        send_unit(16'hD83D, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDC01, 1'b0);
        // Terminator with and without a pending high surrogate.
        send_unit(16'h0000, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0000, 1'b0);
        // High surrogate flagged final, alone and after a pending one.
        send_unit(16'hD800, 1'b1);
        send_unit(16'hD801, 1'b0);
        send_unit(16'hDBFE, 1'b1);
        // Final flag on a plain unit after a pending high surrogate, and on a low half.
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0043, 1'b1);
        send_unit(16'hD9AB, 1'b0);
        send_unit(16'hDE55, 1'b1);

        // Random part: mostly well-formed pairs and plain units, some noise.
        while (sent < RANDOM_UNITS)
        begin
            if (sent >= 30 && !hold_started)
            begin
                hold_started = 1'b1;
                hold_off_go <= 1'b1;
                tx_burst = 20;
            end
            if (sent >= 75 && !paused)
            begin
                paused = 1'b1;
                unit_if.valid <= 1'b0;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_unit({6'b110110, 10'($urandom)}, 1'b0);
                send_unit({6'b110111, 10'($urandom)}, random_final());
                sent += 2;
            end
            else if (pick < 75)
            begin
                send_unit(random_bmp(), random_final());
                sent++;
            end
            else if (pick < 82)
            begin
                send_unit({6'b110110, 10'($urandom)}, random_final());
                sent++;
            end
            else if (pick < 89)
            begin
                send_unit({6'b110111, 10'($urandom)}, random_final());
                sent++;
            end
            else if (pick < 94)
            begin
                send_unit(16'h0000, random_final());
                sent++;
            end
            else
            begin
                send_unit(16'($urandom), random_final());
                sent++;
            end
        end

        // Let every owed byte arrive, then allow the pipeline to settle.
        unit_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (fail_count == 0 && expected_left == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
